/* sv/pdv_pkg.sv */
// pdv_pkg: widths, sequencer states, product steps and control bundle
// for the pairwise difference variance block; no dependencies
`default_nettype none

package pdv_pkg;

    localparam int MAX_SAMPLES = 4096;

    localparam int VAL_W   = 24;               // one Q8.16 log expression
    localparam int DIFF_W  = VAL_W + 1;        // signed a - b
    localparam int MAG_W   = VAL_W;            // |a - b|
    localparam int CNT_W   = 13;               // valid pair count, holds MAX_SAMPLES
    localparam int DSUM_W  = 38;               // signed sum of differences
    localparam int SQSUM_W = 60;               // sum of squared differences
    localparam int SMAG_W  = DSUM_W - 1;       // |diff_sum|
    localparam int MUL_W   = 32;               // shared multiplier operand
    localparam int PROD_W  = 2 * MUL_W;
    localparam int NUM_W   = 74;               // n*sumsq - sum^2
    localparam int DEN_W   = 2 * CNT_W;        // n*(n-1)
    localparam int VAR_W   = 49;
    localparam int ITER_W  = $clog2(NUM_W + 1);

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_WAIT,
        ST_PROD,
        ST_ACC,
        ST_DIV_GO,
        ST_DIV,
        ST_DONE
    } pdv_state_t;

    // partial products of the final result, in issue order
    typedef enum logic [2:0] {
        STEP_NSQ_LO,
        STEP_NSQ_HI,
        STEP_SM_LL,
        STEP_SM_LH,
        STEP_SM_HH,
        STEP_DEN
    } pdv_step_t;

    typedef struct packed {
        logic      s_ready;
        logic      capture;
        logic      sq_issue;
        logic      fin_prep;
        logic      prod_issue;
        logic      prod_acc;
        pdv_step_t step;
        logic      div_start;
        logic      out_load;
    } pdv_ctrl_t;

endpackage

`default_nettype wire

/* sv/pdv_mul.sv */
// pdv_mul: shared unsigned multiplier with registered product
// depends on pdv_pkg
`default_nettype none

module pdv_mul (
    input  wire logic                       aclk,
    input  wire logic                       en,
    input  wire logic [pdv_pkg::MUL_W-1:0]  op_a,
    input  wire logic [pdv_pkg::MUL_W-1:0]  op_b,
    output      logic [pdv_pkg::PROD_W-1:0] prod
);
    import pdv_pkg::*;

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

/* sv/pdv_div.sv */
// pdv_div: restoring divider, one quotient bit per cycle
// depends on pdv_pkg
`default_nettype none

module pdv_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [pdv_pkg::NUM_W-1:0] num,
    input  wire logic [pdv_pkg::DEN_W-1:0] den,
    output      logic                      done,
    output      logic [pdv_pkg::NUM_W-1:0] quot
);
    import pdv_pkg::*;

    logic [NUM_W-1:0]  work_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    rem_sh;
    logic              qbit;
    logic [DEN_W:0]    rem_sub;

    always_comb begin
        rem_sh  = {rem_reg, work_reg[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        qbit    = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                iter_reg <= '0;
            end else if (busy_reg) begin
                iter_reg <= iter_reg + 1'b1;
                if (iter_reg == ITER_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= num;
            rem_reg  <= '0;
            den_reg  <= den;
        end else if (busy_reg) begin
            work_reg <= {work_reg[NUM_W-2:0], qbit};
            rem_reg  <= qbit ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = work_reg;

endmodule

`default_nettype wire

/* sv/pdv_ctrl.sv */
// pdv_ctrl: sequencer for sample intake, final products and divide
// depends on pdv_pkg
`default_nettype none

module pdv_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               last_item,
    input  wire logic               n_ge2,
    input  wire logic               div_done,
    input  wire logic               out_free,
    output      pdv_pkg::pdv_ctrl_t ctl
);
    import pdv_pkg::*;

    pdv_state_t state_reg, state_next;
    pdv_step_t  step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_NSQ_LO;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_WAIT) begin
                step_reg <= STEP_NSQ_LO;
            end else if (state_reg == ST_ACC) begin
                step_reg <= pdv_step_t'(3'(step_reg) + 3'd1);
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_SQR;
            ST_SQR:    state_next = last_item ? ST_WAIT : ST_IDLE;
            ST_WAIT:   state_next = n_ge2 ? ST_PROD : ST_DONE;
            ST_PROD:   state_next = ST_ACC;
            ST_ACC:    state_next = (step_reg == STEP_DEN) ? ST_DIV_GO : ST_PROD;
            ST_DIV_GO: state_next = ST_DIV;
            ST_DIV:    if (div_done) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctl      = '0;
        ctl.step = step_reg;
        case (state_reg)
            ST_IDLE: begin
                ctl.s_ready = 1'b1;
                ctl.capture = s_valid;
            end
            ST_SQR:    ctl.sq_issue   = 1'b1;
            ST_WAIT:   ctl.fin_prep   = 1'b1;
            ST_PROD:   ctl.prod_issue = 1'b1;
            ST_ACC:    ctl.prod_acc   = 1'b1;
            ST_DIV_GO: ctl.div_start  = 1'b1;
            ST_DONE:   ctl.out_load   = out_free;
            default:   ctl.s_ready    = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

/* sv/pairwise_difference_variance.sv */
// pairwise_difference_variance: unbiased sample variance of a - b over a run
// of samples; depends on pdv_pkg, pdv_mul, pdv_div, pdv_ctrl
//
//  channel   dir  tdata (lsb first)                          tuser     tlast
//  s_        in   value_a[23:0] a_valid[24] value_b[48:25]   -         last
//                 b_valid[49], zero pad to 56
//  m_        out  variance[48:0] pair_total[61:49], pad 64   defined   -
//
// a sample is accepted, then its square is formed on the shared multiplier
// a last item then runs six partial products on the shared 32x32 multiplier,
// each issued and then accumulated, followed by a bit-serial divide
// reset (aresetn low, synchronous) clears sums, count, sequencer and m_tvalid
// a finished result sits in the output register; the block then takes new
// items and only holds at the next result until the previous one is taken
`default_nettype none

module pairwise_difference_variance (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // value_a, a_valid, value_b, b_valid
    input  wire logic [pdv_pkg::IN_DATA_W-1:0]       s_tdata,
    input  wire logic                                s_tlast,
    input  wire logic                                s_tvalid,
    output      logic                                s_tready,
    // variance, pair_total
    output      logic [pdv_pkg::OUT_DATA_W-1:0]      m_tdata,
    // defined
    output      logic                                m_tuser,
    output      logic                                m_tvalid,
    input  wire logic                                m_tready
);
    import pdv_pkg::*;

    // input fields
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic                    a_valid;
    logic                    b_valid;

    assign value_a = s_tdata[VAL_W-1:0];
    assign a_valid = s_tdata[VAL_W];
    assign value_b = s_tdata[2*VAL_W:VAL_W+1];
    assign b_valid = s_tdata[2*VAL_W+1];

    // running state
    logic signed [DSUM_W-1:0] diff_sum_reg;
    logic [SQSUM_W-1:0]       square_sum_reg;
    logic [CNT_W-1:0]         valid_count_reg;

    // per-sample pipeline
    logic [MAG_W-1:0]         d_mag_reg;
    logic                     last_reg;
    logic                     sq_pend_reg;

    // final computation
    logic [SMAG_W-1:0]        smag_reg;
    logic [NUM_W-1:0]         num_reg;
    logic [DEN_W-1:0]         den_reg;

    // output register
    logic [VAR_W-1:0]         var_out_reg;
    logic [CNT_W-1:0]         total_out_reg;
    logic                     defined_out_reg;
    logic                     m_valid_reg;

    pdv_ctrl_t                ctl;
    logic                     out_free;
    logic                     n_ge2;
    logic                     take;
    logic signed [DIFF_W-1:0] diff;
    logic [MAG_W-1:0]         diff_mag;

    logic [MUL_W-1:0]         mul_a;
    logic [MUL_W-1:0]         mul_b;
    logic [PROD_W-1:0]        prod;
    logic                     mul_en;

    logic                     div_done;
    logic [NUM_W-1:0]         quot;
    logic [VAR_W-1:0]         var_next;

    assign out_free = !m_valid_reg || m_tready;
    assign n_ge2    = (valid_count_reg >= CNT_W'(2));

    // difference of one sample and whether it counts
    always_comb begin
        take     = a_valid && b_valid && (valid_count_reg < CNT_W'(MAX_SAMPLES));
        diff     = DIFF_W'(value_a) - DIFF_W'(value_b);
        diff_mag = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    pdv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .last_item (last_reg),
        .n_ge2     (n_ge2),
        .div_done  (div_done),
        .out_free  (out_free),
        .ctl       (ctl)
    );

    // operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (ctl.sq_issue) begin
            mul_a = MUL_W'(d_mag_reg);
            mul_b = MUL_W'(d_mag_reg);
        end else begin
            case (ctl.step)
                STEP_NSQ_LO: begin
                    mul_a = MUL_W'(valid_count_reg);
                    mul_b = square_sum_reg[MUL_W-1:0];
                end
                STEP_NSQ_HI: begin
                    mul_a = MUL_W'(valid_count_reg);
                    mul_b = MUL_W'(square_sum_reg[SQSUM_W-1:MUL_W]);
                end
                STEP_SM_LL: begin
                    mul_a = smag_reg[MUL_W-1:0];
                    mul_b = smag_reg[MUL_W-1:0];
                end
                STEP_SM_LH: begin
                    mul_a = smag_reg[MUL_W-1:0];
                    mul_b = MUL_W'(smag_reg[SMAG_W-1:MUL_W]);
                end
                STEP_SM_HH: begin
                    mul_a = MUL_W'(smag_reg[SMAG_W-1:MUL_W]);
                    mul_b = MUL_W'(smag_reg[SMAG_W-1:MUL_W]);
                end
                STEP_DEN: begin
                    mul_a = MUL_W'(valid_count_reg);
                    mul_b = MUL_W'(valid_count_reg - CNT_W'(1));
                end
                default: begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    assign mul_en = ctl.sq_issue || ctl.prod_issue;

    pdv_mul u_mul (
        .aclk (aclk),
        .en   (mul_en),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pdv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (quot)
    );

    // quotient beyond the result width saturates
    assign var_next = (|quot[NUM_W-1:VAR_W]) ? {VAR_W{1'b1}} : quot[VAR_W-1:0];

    // running sums and count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            diff_sum_reg    <= '0;
            square_sum_reg  <= '0;
            valid_count_reg <= '0;
            sq_pend_reg     <= 1'b0;
        end else begin
            sq_pend_reg <= ctl.sq_issue;
            if (ctl.out_load) begin
                diff_sum_reg    <= '0;
                square_sum_reg  <= '0;
                valid_count_reg <= '0;
            end else begin
                if (ctl.capture && take) begin
                    diff_sum_reg    <= diff_sum_reg + DSUM_W'(diff);
                    valid_count_reg <= valid_count_reg + CNT_W'(1);
                end
                // square of the previous sample lands in the cycle after its multiply
                if (sq_pend_reg) begin
                    square_sum_reg <= square_sum_reg + SQSUM_W'(prod);
                end
            end
        end
    end

    // sample capture, skipped samples square to zero
    always_ff @(posedge aclk) begin
        if (ctl.capture) begin
            d_mag_reg <= take ? diff_mag : '0;
            last_reg  <= s_tlast;
        end
    end

    // numerator built from partial products, then the divisor
    always_ff @(posedge aclk) begin
        if (ctl.fin_prep) begin
            smag_reg <= diff_sum_reg[DSUM_W-1] ? SMAG_W'(-diff_sum_reg)
                                               : SMAG_W'(diff_sum_reg);
        end
        if (ctl.prod_acc) begin
            case (ctl.step)
                STEP_NSQ_LO: num_reg <= NUM_W'(prod);
                STEP_NSQ_HI: num_reg <= num_reg + NUM_W'({prod, {MUL_W{1'b0}}});
                STEP_SM_LL:  num_reg <= num_reg - NUM_W'(prod);
                STEP_SM_LH:  num_reg <= num_reg - NUM_W'({prod, {(MUL_W + 1){1'b0}}});
                STEP_SM_HH:  num_reg <= num_reg - NUM_W'({prod, {(2 * MUL_W){1'b0}}});
                STEP_DEN:    den_reg <= prod[DEN_W-1:0];
                default:     num_reg <= num_reg;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            var_out_reg     <= n_ge2 ? var_next : '0;
            total_out_reg   <= valid_count_reg;
            defined_out_reg <= n_ge2;
        end
    end

    assign s_tready = ctl.s_ready;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = defined_out_reg;
    assign m_tdata  = {{(OUT_DATA_W - VAR_W - CNT_W){1'b0}}, total_out_reg, var_out_reg};

    // no second item taken while one is being worked on
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while busy");

    // the count never passes its cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("valid pair count above cap");

    // defined agrees with the reported pair total
    a_defined_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (defined_out_reg == (total_out_reg >= CNT_W'(2))))
        else $error("defined flag disagrees with pair total");

    // undefined result carries zero variance
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !defined_out_reg) |-> (var_out_reg == '0))
        else $error("nonzero variance on undefined result");

endmodule

`default_nettype wire

/* test/pdv_checker.sv */
// pdv_checker: watches both stream channels of pairwise_difference_variance,
// predicts each variance result and compares it field by field; needs pdv_pkg
`default_nettype none

module pdv_checker (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic [pdv_pkg::IN_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    input  wire logic                              s_tready,
    input  wire logic [pdv_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  wire logic                              m_tuser,
    input  wire logic                              m_tvalid,
    input  wire logic                              m_tready,
    output int                                     mismatch_count,
    output int                                     results_awaited,
    output int                                     pairs_closed,
    output int                                     undefined_pairs,
    output int                                     capped_pairs
);
    timeunit 1ns;
    timeprecision 1ps;

    import pdv_pkg::*;

    typedef struct packed {
        logic [VAR_W-1:0] variance;
        logic [CNT_W-1:0] pair_total;
        logic             defined;
    } pair_result_t;

    // running sums of the pair being gathered
    logic signed [DSUM_W-1:0]  diff_acc;
    logic        [SQSUM_W-1:0] square_acc;
    int unsigned               pair_cnt;
    bit                        cap_hit;

    pair_result_t awaited_variances[$];
    int           errors;

    initial begin
        diff_acc   = '0;
        square_acc = '0;
        pair_cnt   = 0;
        cap_hit    = 1'b0;
        errors     = 0;
    end

    function automatic void absorb_sample(input logic signed [VAL_W-1:0] a,
                                          input logic signed [VAL_W-1:0] b,
                                          input bit both);
        logic signed [DIFF_W-1:0] d;
        logic        [MAG_W-1:0]  mag;
        if (both && pair_cnt >= MAX_SAMPLES) begin
            cap_hit = 1'b1;
        end else if (both) begin
            d   = a - b;
            mag = (d < 0) ? -d : d;
            diff_acc   = diff_acc + d;
            square_acc = square_acc + mag * mag;
            pair_cnt++;
        end
    endfunction

    // unbiased variance (n*sumsq - sum^2) / (n*(n-1)), truncated and saturated, then clear
    function automatic pair_result_t close_pair();
        pair_result_t r;
        logic [DSUM_W-1:0] smag;
        logic [127:0]      num, den, quo;
        r.pair_total = pair_cnt[CNT_W-1:0];
        r.defined    = (pair_cnt >= 2);
        r.variance   = '0;
        if (pair_cnt >= 2) begin
            smag = diff_acc[DSUM_W-1] ? -diff_acc : diff_acc;
            num  = 128'(pair_cnt) * 128'(square_acc) - 128'(smag) * 128'(smag);
            den  = 128'(pair_cnt) * 128'(pair_cnt - 1);
            quo  = num / den;
            r.variance = (quo >> VAR_W) != 0 ? '1 : quo[VAR_W-1:0];
        end
        pairs_closed++;
        if (pair_cnt < 2)
            undefined_pairs++;
        if (cap_hit)
            capped_pairs++;
        diff_acc   = '0;
        square_acc = '0;
        pair_cnt   = 0;
        cap_hit    = 1'b0;
        return r;
    endfunction

    function automatic void check_field(input string what,
                                        input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        pair_result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (awaited_variances.size() == 0) begin
                    $display("%0t unexpected result: expected none, got variance %0d count %0d",
                             $time, m_tdata[VAR_W-1:0], m_tdata[VAR_W+CNT_W-1:VAR_W]);
                    errors++;
                end else begin
                    want = awaited_variances.pop_front();
                    check_field("variance", want.variance, m_tdata[VAR_W-1:0]);
                    check_field("pair_total", want.pair_total,
                                m_tdata[VAR_W+CNT_W-1:VAR_W]);
                    check_field("defined", want.defined, m_tuser);
                end
                check_field("tdata pad", 0, m_tdata[OUT_DATA_W-1:VAR_W+CNT_W]);
            end
            if (s_tvalid && s_tready) begin
                absorb_sample(s_tdata[VAL_W-1:0], s_tdata[2*VAL_W:VAL_W+1],
                              s_tdata[VAL_W] && s_tdata[2*VAL_W+1]);
                if (s_tlast)
                    awaited_variances.push_back(close_pair());
            end
        end
        // published with nonblocking so readers after the edge see a stable value
        mismatch_count  <= errors;
        results_awaited <= awaited_variances.size();
    end

endmodule

`default_nettype wire

/* test/tb.sv */
// tb: stimulus and verdict for pairwise_difference_variance; the pdv_checker
// instance beside the block predicts and compares; needs pdv_pkg and the rtl
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pdv_pkg::*;

    typedef enum int { VAL_FULL, VAL_EXTREME, VAL_NEAR } val_style_t;

    localparam int LONG_HOLD   = 400;    // cycles the receiver holds off once
    localparam int RAND_ITEMS  = 700;    // random samples after the directed part
    localparam int QUIET_AFTER = 600;    // no idling from here on

    logic                   aclk;
    logic                   aresetn;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready;

    int mismatch_count, results_awaited, pairs_closed, undefined_pairs, capped_pairs;

    // written only by the stimulus process
    bit quiet;
    int gap_odds;
    int hold_tickets;
    int samples_sent;

    pairwise_difference_variance uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    pdv_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mismatch_count  (mismatch_count),
        .results_awaited (results_awaited),
        .pairs_closed    (pairs_closed),
        .undefined_pairs (undefined_pairs),
        .capped_pairs    (capped_pairs)
    );

    // 100 MHz clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // hard stop in case the block hangs
    initial begin
        #5_000_000;
        $display("timeout: %0d results still awaited", results_awaited);
        $display("** pairwise_difference_variance: FAILED **");
        $finish;
    end

    function automatic logic [VAL_W-1:0] pick_value(input val_style_t style);
        case (style)
            VAL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0:       return 24'h7FFFFF;
                    1:       return 24'h800000;
                    2:       return 24'h000000;
                    3:       return 24'h000001;
                    default: return 24'hFFFFFF;
                endcase
            end
            // within about +-1.0 in Q8.16
            VAL_NEAR: return 24'($urandom_range(0, 24'h01FFFF)) - 24'h010000;
            default:  return 24'($urandom);
        endcase
    endfunction

    // one sample; tvalid stays high into the next item unless a gap is drawn
    task automatic offer_sample(input logic [VAL_W-1:0] a, input bit av,
                                input logic [VAL_W-1:0] b, input bit bv,
                                input bit last);
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        // tdata: value_a, a_valid, value_b, b_valid, zero pad
        s_tdata  <= {6'b0, bv, b, av, a};
        s_tlast  <= last;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // one gene pair: len samples, last on the final one
    task automatic offer_frame(input int len, input int valid_pct, input val_style_t style);
        logic [VAL_W-1:0] a, b;
        bit av, bv;
        for (int i = 0; i < len; i++) begin
            a = pick_value(style);
            b = pick_value(style);
            if ($urandom_range(1, 100) <= valid_pct) begin
                av = 1'b1;
                bv = 1'b1;
            end else begin
                av = $urandom_range(0, 1);
                bv = $urandom_range(0, 1);
            end
            offer_sample(a, av, b, bv, i == len - 1);
        end
    endtask

    // sender stops offering until every predicted result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_awaited != 0);
    endtask

    // receiver: ready runs, short stall bursts, and one long hold on request
    initial begin : result_sink
        int holds_served;
        holds_served = 0;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_tickets > holds_served) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                holds_served++;
            end else if (!quiet && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int random_items, len, pct, r, waited;
        val_style_t style;

        quiet        = 1'b0;
        gap_odds     = 6;
        hold_tickets = 0;
        samples_sent = 0;
        random_items = 0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tvalid     = 1'b0;
        aresetn      = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // last with no valid pair at all, and with only one flag set
        offer_sample(24'h000000, 1'b0, 24'h000000, 1'b0, 1'b1);
        offer_sample(24'h123456, 1'b1, 24'h654321, 1'b0, 1'b1);
        // a single valid pair is not enough for a variance
        offer_sample(24'h7FFFFF, 1'b1, 24'h800000, 1'b1, 1'b1);
        // largest differences of both signs: largest variance
        offer_sample(24'h7FFFFF, 1'b1, 24'h800000, 1'b1, 1'b0);
        offer_sample(24'h800000, 1'b1, 24'h7FFFFF, 1'b1, 1'b1);
        // constant difference gives zero variance
        offer_sample(24'h050000, 1'b1, 24'h030000, 1'b1, 1'b0);
        offer_sample(24'h050000, 1'b1, 24'h030000, 1'b1, 1'b0);
        offer_sample(24'h050000, 1'b1, 24'h030000, 1'b1, 1'b1);
        // half-valid samples skipped inside a run
        offer_sample(24'h000001, 1'b1, 24'h000002, 1'b0, 1'b0);
        offer_sample(24'hFFFFFF, 1'b0, 24'h7FFFFF, 1'b1, 1'b0);
        offer_sample(24'h7FFFFF, 1'b1, 24'h000000, 1'b1, 1'b0);
        offer_sample(24'h000000, 1'b1, 24'h7FFFFF, 1'b1, 1'b0);
        offer_sample(24'h800000, 1'b1, 24'h800000, 1'b1, 1'b1);
        // smallest nonzero spread
        offer_sample(24'h000000, 1'b1, 24'h000000, 1'b1, 1'b0);
        offer_sample(24'hFFFFFF, 1'b1, 24'h000000, 1'b1, 1'b1);

        // long receiver hold while short runs keep coming: input must stall
        gap_odds = 0;
        hold_tickets++;
        repeat (12) offer_frame(2, 100, VAL_FULL);
        drain_results();

        // random runs, mostly well formed, some with missing values
        while (random_items < RAND_ITEMS) begin
            if (random_items >= QUIET_AFTER)
                quiet = 1'b1;
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 6;
            r = $urandom_range(0, 99);
            if (r < 10)
                len = 1;
            else if (r < 85)
                len = $urandom_range(2, 12);
            else
                len = $urandom_range(13, 40);
            pct   = ($urandom_range(0, 9) == 0) ? 30 : 90;
            style = val_style_t'($urandom_range(0, 2));
            offer_frame(len, pct, style);
            random_items += len;
        end

        // let the last divide finish and its result drain
        s_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge aclk);
            waited++;
        end while (results_awaited != 0 && waited < 20000);
        repeat (120) @(posedge aclk);

        $display("run covered %0d samples in %0d pair runs", samples_sent, pairs_closed);
        $display("  %0d runs with under two valid pairs, %0d past the sample limit",
                 undefined_pairs, capped_pairs);
        if (mismatch_count == 0 && results_awaited == 0) begin
            $display("** pairwise_difference_variance: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatch_count, results_awaited);
            $display("** pairwise_difference_variance: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
